@@ design/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	`ASSERT_CLK(lbl, clk, rst_n, (ante) |-> (cons))

`endif

@@ design/lbs_pkg.sv @@
package lbs_pkg;

	localparam int NUM_LEDS_DEF     = 10;
	localparam int WORD_BITS_DEF    = 16;
	localparam int LATCH_PULSES_DEF = 4;

	localparam int CODE_W      = 8;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_SET  = 2'd1;
	localparam logic [1:0] CMD_SHOW = 2'd2;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_SET  = 2'd1;
	localparam logic [1:0] OP_SHOW = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] CFG_COMMAND_WORD = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LATCH_WAIT   = 1'd1;

	localparam logic [15:0] LATCH_WAIT_RESET = 16'd1000;

	typedef struct packed {
		logic [1:0] command;
		logic [3:0] led_index;
		logic [8:0] brightness;
	} item_t;

	typedef struct packed {
		logic data_pin;
		logic clock_pin;
		logic busy_res;
		logic done_res;
	} result_t;

	// Classified word passed from the front end to the sequencer.
	typedef struct packed {
		logic [1:0]        kind;
		logic [3:0]        led_index;
		logic [CODE_W-1:0] code;
	} op_t;

	// Saturate to 1.0, keep the top bits as a level of 0 to 8 and make a
	// thermometer code with that many low ones.
	function automatic logic [CODE_W-1:0] brightness_code(input logic [8:0] b);
		logic [8:0] sat;
		logic [3:0] lvl;
		sat = (b > 9'd256) ? 9'd256 : b;
		lvl = sat[8:5];
		return 8'hFF >> (4'd8 - lvl);
	endfunction

endpackage

@@ design/lbs_front.sv @@
module lbs_front
	import lbs_pkg::*;
#(
	parameter int NUM_LEDS = NUM_LEDS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t item,
	output logic  op_valid,
	output op_t   op,
	input  logic  op_pop
);

	localparam int DEPTH = 2;

	op_t        queue_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	op_t        op_new;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		op_new.led_index = item.led_index;
		op_new.code      = brightness_code(item.brightness);
		if ({1'b0, item.led_index} > 5'(NUM_LEDS - 1)) begin
			op_new.led_index = 4'(NUM_LEDS - 1);
		end
		unique case (item.command)
			CMD_SET:  op_new.kind = OP_SET;
			CMD_SHOW: op_new.kind = OP_SHOW;
			default:  op_new.kind = OP_TICK;
		endcase
	end

	assign full     = (count_q == 2'(DEPTH));
	assign op_valid = (count_q != 2'd0);
	assign op       = queue_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = op_pop && op_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			queue_q[wr_ptr_q] <= op_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

@@ design/lbs_back.sv @@
module lbs_back
	import lbs_pkg::*;
#(
	parameter int NUM_LEDS     = NUM_LEDS_DEF,
	parameter int WORD_BITS    = WORD_BITS_DEF,
	parameter int LATCH_PULSES = LATCH_PULSES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   op_valid,
	input  op_t                    op,
	output logic                   op_pop,
	output logic                   empty,
	input  logic                   pop,
	output result_t                result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int FRAME_WORDS = NUM_LEDS + 3;
	localparam int WC_W  = $clog2(FRAME_WORDS);
	localparam int BC_W  = $clog2(WORD_BITS);
	localparam int PC_W  = $clog2(LATCH_PULSES + 1);
	localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int DEPTH = 2;

	localparam logic [2:0] SEQ_IDLE       = 3'd0;
	localparam logic [2:0] SEQ_DATA       = 3'd1;
	localparam logic [2:0] SEQ_CLOCK      = 3'd2;
	localparam logic [2:0] SEQ_LATCH_LOW  = 3'd3;
	localparam logic [2:0] SEQ_WAIT       = 3'd4;
	localparam logic [2:0] SEQ_PULSE_HIGH = 3'd5;
	localparam logic [2:0] SEQ_PULSE_LOW  = 3'd6;

	logic [15:0]       command_word_q;
	logic [15:0]       latch_wait_q;
	logic [CODE_W-1:0] led_codes_q [NUM_LEDS];
	logic              data_q;
	logic              clock_q;
	logic [WC_W-1:0]   word_q;
	logic [BC_W-1:0]   bit_q;
	logic [2:0]        step_q;
	logic [15:0]       wait_q;
	logic [PC_W-1:0]   pulse_q;

	logic              data_d;
	logic              clock_d;
	logic [WC_W-1:0]   word_d;
	logic [BC_W-1:0]   bit_d;
	logic [2:0]        step_d;
	logic [15:0]       wait_d;
	logic [PC_W-1:0]   pulse_d;
	logic              done_d;

	logic [WC_W-1:0]      led_sel;
	logic [WORD_BITS-1:0] frame_word;
	logic [BC_W-1:0]      bit_pos;
	logic                 fire;

	result_t    res_q [DEPTH];
	result_t    res_new;
	logic       res_wr_q;
	logic       res_rd_q;
	logic [1:0] res_cnt_q;
	logic       res_pop;

	assign cfg_ready = 1'b1;
	assign fire      = op_valid && (res_cnt_q != 2'(DEPTH));
	assign op_pop    = fire;
	assign empty     = (res_cnt_q == 2'd0);
	assign result    = res_q[res_rd_q];
	assign res_pop   = pop && !empty;

	// Word 0 is the mode word, then one word per LED, then padding zeros.
	always_comb begin
		led_sel = word_q - WC_W'(1);
		if (word_q == '0) begin
			frame_word = command_word_q[WORD_BITS-1:0];
		end else if (word_q <= WC_W'(NUM_LEDS)) begin
			frame_word = WORD_BITS'(led_codes_q[led_sel[IDX_W-1:0]]);
		end else begin
			frame_word = '0;
		end
		bit_pos = BC_W'(WORD_BITS - 1) - bit_q;
	end

	always_comb begin
		data_d  = data_q;
		clock_d = clock_q;
		word_d  = word_q;
		bit_d   = bit_q;
		step_d  = step_q;
		wait_d  = wait_q;
		pulse_d = pulse_q;
		done_d  = 1'b0;
		case (op.kind)
			OP_SET: begin
			end
			OP_SHOW: begin
				if (step_q == SEQ_IDLE) begin
					word_d  = '0;
					bit_d   = '0;
					pulse_d = '0;
					wait_d  = '0;
					step_d  = SEQ_DATA;
				end
			end
			default: begin
				unique case (step_q)
					SEQ_DATA: begin
						data_d = frame_word[bit_pos];
						step_d = SEQ_CLOCK;
					end
					SEQ_CLOCK: begin
						clock_d = ~clock_q;
						step_d  = SEQ_DATA;
						if (bit_q == BC_W'(WORD_BITS - 1)) begin
							bit_d = '0;
							if (word_q == WC_W'(FRAME_WORDS - 1)) begin
								word_d = '0;
								step_d = SEQ_LATCH_LOW;
							end else begin
								word_d = word_q + WC_W'(1);
							end
						end else begin
							bit_d = bit_q + BC_W'(1);
						end
					end
					SEQ_LATCH_LOW: begin
						data_d = 1'b0;
						wait_d = latch_wait_q;
						step_d = SEQ_WAIT;
					end
					SEQ_WAIT: begin
						if (wait_q != 16'd0) begin
							wait_d = wait_q - 16'd1;
						end else begin
							data_d = 1'b1;
							step_d = SEQ_PULSE_LOW;
						end
					end
					SEQ_PULSE_HIGH: begin
						data_d = 1'b1;
						step_d = SEQ_PULSE_LOW;
					end
					SEQ_PULSE_LOW: begin
						data_d = 1'b0;
						if (pulse_q == PC_W'(LATCH_PULSES - 1)) begin
							pulse_d = '0;
							step_d  = SEQ_IDLE;
							done_d  = 1'b1;
						end else begin
							pulse_d = pulse_q + PC_W'(1);
							step_d  = SEQ_PULSE_HIGH;
						end
					end
					default: begin
					end
				endcase
			end
		endcase
		res_new.data_pin  = data_d;
		res_new.clock_pin = clock_d;
		res_new.busy_res  = (step_d != SEQ_IDLE);
		res_new.done_res  = done_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_word_q <= '0;
			latch_wait_q   <= LATCH_WAIT_RESET;
			for (int i = 0; i < NUM_LEDS; i++) begin
				led_codes_q[i] <= '0;
			end
			data_q  <= 1'b0;
			clock_q <= 1'b0;
			word_q  <= '0;
			bit_q   <= '0;
			step_q  <= SEQ_IDLE;
			wait_q  <= '0;
			pulse_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_COMMAND_WORD: command_word_q <= cfg_data;
					CFG_LATCH_WAIT:   latch_wait_q   <= cfg_data;
					default: begin
					end
				endcase
			end
			if (fire) begin
				if (op.kind == OP_SET) begin
					led_codes_q[op.led_index[IDX_W-1:0]] <= op.code;
				end
				data_q  <= data_d;
				clock_q <= clock_d;
				word_q  <= word_d;
				bit_q   <= bit_d;
				step_q  <= step_d;
				wait_q  <= wait_d;
				pulse_q <= pulse_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q[res_wr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= 1'b0;
			res_rd_q  <= 1'b0;
			res_cnt_q <= 2'd0;
		end else begin
			if (fire) begin
				res_wr_q <= ~res_wr_q;
			end
			if (res_pop) begin
				res_rd_q <= ~res_rd_q;
			end
			res_cnt_q <= res_cnt_q + 2'(fire) - 2'(res_pop);
		end
	end

endmodule

@@ design/led_bar_serial_frame_sender_unit.sv @@
// Channel   Handshake            Payload
// item      push / full          item_t: command, led_index, brightness
// result    pop / empty          result_t: data_pin, clock_pin, busy_res, done_res
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Every word pushed yields exactly one result word, in order, one per cycle
// sustained unless held. A word enters the command queue, is written to the result
// queue when the sequencer takes it and can be popped from there; the sequencer
// step (counters, pin levels, code select) is the loop that sets this rate.
// Reset clears the LED codes, pin levels, counters and both queues at once.
// A full result queue holds the sequencer; the two-entry command queue absorbs input.
module led_bar_serial_frame_sender_unit
	import lbs_pkg::*;
#(
	parameter int NUM_LEDS     = NUM_LEDS_DEF,
	parameter int WORD_BITS    = WORD_BITS_DEF,
	parameter int LATCH_PULSES = LATCH_PULSES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  item_t                  item,
	output logic                   empty,
	input  logic                   pop,
	output result_t                result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic op_valid;
	op_t  op;
	logic op_pop;

	lbs_front #(
		.NUM_LEDS(NUM_LEDS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.op_valid(op_valid),
		.op      (op),
		.op_pop  (op_pop)
	);

	lbs_back #(
		.NUM_LEDS    (NUM_LEDS),
		.WORD_BITS   (WORD_BITS),
		.LATCH_PULSES(LATCH_PULSES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op       (op),
		.op_pop   (op_pop),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

endmodule

@@ design/lbs_checker.sv @@
`include "assert_macros.svh"

module lbs_checker
	import lbs_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   push,
	input logic                   full,
	input item_t                  item,
	input logic                   empty,
	input logic                   pop,
	input result_t                result,
	input logic                   cfg_valid,
	input logic                   cfg_ready,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0]  cfg_data
);

	// The word that ends the last latch pulse also ends the sequence.
	`ASSERT_IMPLY(a_done_not_busy, clk, arst_n, !empty && result.done_res, !result.busy_res)

	// The last latch pulse always leaves the data line low.
	`ASSERT_IMPLY(a_done_data_low, clk, arst_n, !empty && result.done_res, !result.data_pin)

	// A waiting result word is held until it is taken.
	`ASSERT_CLK(a_result_held, clk, arst_n, !empty && !pop |=> !empty && $stable(result))

endmodule

bind led_bar_serial_frame_sender_unit lbs_checker u_lbs_checker (.*);
